FILE: rtl/fpf_pkg.sv
package fpf_pkg;

	localparam int unsigned MAX_PAYLOAD = 47;

	localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
	localparam logic [15:0] CRC_POLY      = 16'h1021;

	localparam logic [4:0]  PREAMBLE_RESET = 5'd5;
	localparam logic [23:0] SYNC_RESET     = 24'hC194C1;
	localparam logic [15:0] SEED_RESET     = 16'h1D0F;

	localparam logic [4:0]  PREAMBLE_MIN = 5'd1;
	localparam logic [4:0]  PREAMBLE_MAX = 5'd16;
	localparam logic [4:0]  SYNC_BYTES   = 5'd3;

	typedef enum logic [1:0] {
		REG_PREAMBLE = 2'd0,
		REG_SYNC     = 2'd1,
		REG_SEED     = 2'd2
	} reg_idx_t;

	typedef enum logic {
		FUNC_START   = 1'b0,
		FUNC_PAYLOAD = 1'b1
	} func_t;

	// byte sequence for one input word
	typedef struct packed {
		logic [4:0]  pc;
		logic [4:0]  head;
		logic [23:0] sync;
		logic [7:0]  first;
		logic [7:0]  crc_hi;
		logic [7:0]  crc_lo;
		logic        has_crc;
		logic        err;
	} job_t;

	typedef struct packed {
		logic       in_packet;
		logic [5:0] remaining;
	} ctrl_status_t;

	typedef struct packed {
		logic busy;
	} emit_status_t;

	function automatic logic [7:0] whiten_at(logic [5:0] pos);
		logic [7:0] w;
		case (pos)
			6'd0:  w = 8'hff; 6'd1:  w = 8'h87; 6'd2:  w = 8'hb8; 6'd3:  w = 8'h59;
			6'd4:  w = 8'hb7; 6'd5:  w = 8'ha1; 6'd6:  w = 8'hcc; 6'd7:  w = 8'h24;
			6'd8:  w = 8'h57; 6'd9:  w = 8'h5e; 6'd10: w = 8'h4b; 6'd11: w = 8'h9c;
			6'd12: w = 8'h0e; 6'd13: w = 8'he9; 6'd14: w = 8'hea; 6'd15: w = 8'h50;
			6'd16: w = 8'h2a; 6'd17: w = 8'hbe; 6'd18: w = 8'hb4; 6'd19: w = 8'h1b;
			6'd20: w = 8'hb6; 6'd21: w = 8'hb0; 6'd22: w = 8'h5d; 6'd23: w = 8'hf1;
			6'd24: w = 8'he6; 6'd25: w = 8'h9a; 6'd26: w = 8'he3; 6'd27: w = 8'h45;
			6'd28: w = 8'hfd; 6'd29: w = 8'h2c; 6'd30: w = 8'h53; 6'd31: w = 8'h18;
			6'd32: w = 8'h0c; 6'd33: w = 8'hca; 6'd34: w = 8'hc9; 6'd35: w = 8'hfb;
			6'd36: w = 8'h49; 6'd37: w = 8'h37; 6'd38: w = 8'he5; 6'd39: w = 8'ha8;
			6'd40: w = 8'h51; 6'd41: w = 8'h3b; 6'd42: w = 8'h2f; 6'd43: w = 8'h61;
			6'd44: w = 8'haa; 6'd45: w = 8'h72; 6'd46: w = 8'h18; 6'd47: w = 8'h84;
			6'd48: w = 8'h02; 6'd49: w = 8'h23;
			default: w = 8'h00;
		endcase
		return w;
	endfunction

	// CRC-16, MSB first
	function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		logic        top;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			top = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (top) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/fpf_ctrl.sv
module fpf_ctrl
	import fpf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic         func,
	input  logic [5:0]   payload_length,
	input  logic [7:0]   payload_byte,
	input  logic [4:0]   preamble_count,
	input  logic [23:0]  sync_pattern,
	input  logic [15:0]  crc_seed,
	output job_t         job,
	output ctrl_status_t status
);

	logic        in_packet_q;
	logic [5:0]  remaining_q;
	logic [5:0]  wpos_q;
	logic [15:0] crc_q;

	logic        in_packet_d;
	logic [5:0]  remaining_d;
	logic [5:0]  wpos_d;
	logic [15:0] crc_d;

	logic [4:0]  pc_clamped;
	logic [15:0] crc_new;
	logic [15:0] crc_inv;
	logic [5:0]  crc_pos;
	logic [5:0]  rem_dec;

	always_comb begin
		if (preamble_count < PREAMBLE_MIN) begin
			pc_clamped = PREAMBLE_MIN;
		end else if (preamble_count > PREAMBLE_MAX) begin
			pc_clamped = PREAMBLE_MAX;
		end else begin
			pc_clamped = preamble_count;
		end
	end

	always_comb begin
		in_packet_d = in_packet_q;
		remaining_d = remaining_q;
		wpos_d      = wpos_q;
		crc_d       = crc_q;
		rem_dec     = remaining_q - 6'd1;
		crc_new     = '0;
		crc_pos     = '0;

		job         = '0;
		job.sync    = sync_pattern;

		if (func == FUNC_START) begin
			if (payload_length > 6'(MAX_PAYLOAD)) begin
				job.err     = 1'b1;
				in_packet_d = 1'b0;
				remaining_d = '0;
				wpos_d      = '0;
			end else begin
				crc_new     = crc_feed(crc_seed, {2'b00, payload_length});
				crc_pos     = 6'd1;
				job.pc      = pc_clamped;
				job.head    = pc_clamped + SYNC_BYTES;
				job.first   = {2'b00, payload_length} ^ whiten_at(6'd0);
				job.has_crc = (payload_length == 6'd0);
				crc_d       = crc_new;
				if (payload_length == 6'd0) begin
					in_packet_d = 1'b0;
					remaining_d = '0;
					wpos_d      = '0;
				end else begin
					in_packet_d = 1'b1;
					remaining_d = payload_length;
					wpos_d      = 6'd1;
				end
			end
		end else begin
			if (!in_packet_q || remaining_q == 6'd0) begin
				job.err = 1'b1;
			end else begin
				crc_new     = crc_feed(crc_q, payload_byte);
				crc_pos     = wpos_q + 6'd1;
				job.first   = payload_byte ^ whiten_at(wpos_q);
				job.has_crc = (rem_dec == 6'd0);
				crc_d       = crc_new;
				if (rem_dec == 6'd0) begin
					in_packet_d = 1'b0;
					remaining_d = '0;
					wpos_d      = '0;
				end else begin
					remaining_d = rem_dec;
					wpos_d      = wpos_q + 6'd1;
				end
			end
		end

		crc_inv    = ~crc_new;
		job.crc_hi = crc_inv[15:8] ^ whiten_at(crc_pos);
		job.crc_lo = crc_inv[7:0] ^ whiten_at(crc_pos + 6'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			remaining_q <= '0;
			wpos_q      <= '0;
			crc_q       <= '0;
		end else if (take) begin
			in_packet_q <= in_packet_d;
			remaining_q <= remaining_d;
			wpos_q      <= wpos_d;
			crc_q       <= crc_d;
		end
	end

	assign status.in_packet = in_packet_q;
	assign status.remaining = remaining_q;

endmodule

FILE: rtl/fpf_emit.sv
module fpf_emit
	import fpf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  job_t         job,
	output logic         can_load,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_byte,
	output logic         end_of_packet,
	output logic         frame_error,
	output emit_status_t status
);

	job_t        job_s1;
	logic        job_v_s1;
	logic [4:0]  cnt_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        eop_q;
	logic        err_q;

	logic        adv;
	logic        last;
	logic [4:0]  head_p1;
	logic [4:0]  head_p2;
	logic [4:0]  sync_sel;
	logic [7:0]  sel_byte;
	logic        sel_eop;
	logic        sel_err;

	assign head_p1 = job_s1.head + 5'd1;
	assign head_p2 = job_s1.head + 5'd2;
	assign adv     = job_v_s1 && (!out_valid_q || out_ready);
	assign last    = (cnt_q == job_s1.head && !job_s1.has_crc) || (cnt_q == head_p2);
	assign can_load = !job_v_s1 || (adv && last);
	assign sync_sel = cnt_q - job_s1.pc;

	always_comb begin
		sel_eop = 1'b0;
		sel_err = 1'b0;
		if (cnt_q < job_s1.pc) begin
			sel_byte = PREAMBLE_BYTE;
		end else if (cnt_q < job_s1.head) begin
			case (sync_sel[1:0])
				2'd0:    sel_byte = job_s1.sync[23:16];
				2'd1:    sel_byte = job_s1.sync[15:8];
				default: sel_byte = job_s1.sync[7:0];
			endcase
		end else if (cnt_q == job_s1.head) begin
			sel_byte = job_s1.first;
			sel_err  = job_s1.err;
		end else if (cnt_q == head_p1) begin
			sel_byte = job_s1.crc_hi;
		end else begin
			sel_byte = job_s1.crc_lo;
			sel_eop  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_s1 <= 1'b0;
			cnt_q    <= '0;
		end else if (load) begin
			job_v_s1 <= 1'b1;
			cnt_q    <= '0;
		end else if (adv && last) begin
			job_v_s1 <= 1'b0;
		end else if (adv) begin
			cnt_q <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= sel_byte;
			eop_q      <= sel_eop;
			err_q      <= sel_err;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign end_of_packet = eop_q;
	assign frame_error   = err_q;
	assign status.busy   = job_v_s1;

endmodule

FILE: rtl/fsk_packet_framer_core.sv
// channel | signals                                        | dir
// --------+------------------------------------------------+-----
// in      | in_valid in_ready func payload_length payload_byte | in
// out     | out_valid out_ready out_byte end_of_packet frame_error | out
// cfg     | cfg_valid cfg_ready cfg_index cfg_data          | in
//
// One output byte per cycle while out_ready does not hold the output register.
// A start word emits the clamped preamble count + 4 bytes (+2 for length 0), a
// payload word 1 byte (3 on the last byte), an error 1. The next input word is
// taken in the cycle the current word's last byte loads the output register.
// Reset clears control state only; config registers come up at defaults.
// cfg_ready is always high.
module fsk_packet_framer_core
	import fpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [5:0]  payload_length,
	input  logic [7:0]  payload_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        end_of_packet,
	output logic        frame_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic [4:0]   preamble_q;
	logic [23:0]  sync_q;
	logic [15:0]  seed_q;

	logic         take;
	logic         can_load;
	job_t         job;
	ctrl_status_t ctrl_st;
	emit_status_t emit_st;

	assign cfg_ready = 1'b1;
	assign take      = in_valid && can_load;
	assign in_ready  = can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PREAMBLE_RESET;
			sync_q     <= SYNC_RESET;
			seed_q     <= SEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PREAMBLE: preamble_q <= cfg_data[4:0];
				REG_SYNC:     sync_q     <= cfg_data;
				REG_SEED:     seed_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	fpf_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.func           (func),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.preamble_count (preamble_q),
		.sync_pattern   (sync_q),
		.crc_seed       (seed_q),
		.job            (job),
		.status         (ctrl_st)
	);

	fpf_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (take),
		.job           (job),
		.can_load      (can_load),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.end_of_packet (end_of_packet),
		.frame_error   (frame_error),
		.status        (emit_st)
	);

`ifndef NO_ASSERTIONS
	a_eop_not_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(end_of_packet && frame_error))
		else $error("end_of_packet and frame_error together");

	a_pkt_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_st.in_packet == (ctrl_st.remaining != 6'd0))
		else $error("packet state and byte count disagree");

	a_emit_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_st.busy && !out_valid) |=> out_valid)
		else $error("pending word did not reach output register");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!emit_st.busy |-> in_ready)
		else $error("input stalled while sequencer idle");
`endif

endmodule
